// ===== hw/rtl/wave_header_duration_parser_assert.svh =====
// Assertion macros shared by the wave header parser RTL.
// Each macro expands to one clocked concurrent assertion on clk_i and rst_ni.
`ifndef WAVE_HEADER_DURATION_PARSER_ASSERT_SVH
`define WAVE_HEADER_DURATION_PARSER_ASSERT_SVH

// Same-cycle implication.
`define WHDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WHDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/whdp_pkg.sv =====
// Package of the wave header parser: tags, limits, status codes and types.
// It depends on nothing; the parser top level imports it.
`timescale 1ns / 1ps
`default_nettype none

package whdp_pkg;

  localparam int unsigned DurW  = 32;
  localparam int unsigned ProdW = 48;
  localparam int unsigned NumW  = 41;
  localparam int unsigned CntW  = $clog2(NumW + 1);

  typedef logic [7:0]      byte_t;
  typedef logic [DurW-1:0] dur_t;
  typedef logic [1:0]      status_t;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [5:0] MinFileBytes = 6'd44;
  localparam logic [4:0] FmtNeeded    = 5'd16;
  localparam logic [9:0] Thousand     = 10'd1000;

  localparam status_t StatusOk      = 2'd0;
  localparam status_t StatusNotWave = 2'd1;
  localparam status_t StatusShortFmt = 2'd2;
  localparam status_t StatusBadData = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/wave_header_duration_parser.sv =====
// Top level of the wave header parser: byte-wise chunk walker and serial divider.
// Depends on whdp_pkg and on wave_header_duration_parser_assert.svh.
//
// Usage: a wave file enters one byte per transfer on file_byte_i, with
// last_byte_i high on its final byte. A transfer happens at a rising edge
// with in_valid_i high and in_stall_o low. Bytes are taken one per cycle
// while the header is walked. After the final byte the block stalls its
// input while it forms the result: it forms the rate times align product,
// checks the status, then, for a good file only, runs a restoring divider
// on the 41-bit numerator that retires one quotient bit per cycle, and last
// loads the output register once that register is free. An erroneous file
// skips the divider; for either, the input stays stalled until that load.
// The result (duration_ms_o, status_o) sits in an output register under
// out_valid_o until a cycle with out_stall_i low; while it waits, the next
// file may already stream in, and after a further final byte the new
// result waits, with the input stalled, for the output register to free up.
// Reset puts the parser at the start of a file with no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "wave_header_duration_parser_assert.svh"

module wave_header_duration_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire whdp_pkg::byte_t  file_byte_i,
  input  wire logic             last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output whdp_pkg::dur_t        duration_ms_o,
  output whdp_pkg::status_t     status_o
);
  import whdp_pkg::*;

  typedef enum logic [3:0] {
    P_RIFF, P_RLEN, P_WAVE, P_CID, P_CSIZE, P_FMT, P_SKIP, P_DATA, P_HALT
  } phase_e;

  typedef enum logic [2:0] {
    C_PARSE, C_MULT, C_CHECK, C_DIV, C_HOLD
  } ctl_e;

  phase_e ctl_phase_d, phase_q;
  ctl_e ctl_d, ctl_q;

  logic [5:0] byte_cnt_d, byte_cnt_q;
  logic [31:0] field_d, field_q;
  logic [1:0] idx_d, idx_q;
  logic [31:0] tag_d, tag_q;
  logic [31:0] rem_cnt_d, rem_cnt_q;
  logic [4:0] fmt_taken_d, fmt_taken_q;
  logic [31:0] rate_d, rate_q;
  logic [15:0] align_d, align_q;
  logic [31:0] data_len_d, data_len_q;
  status_t err_d, err_q;

  logic [ProdW-1:0] prod_d, prod_q;
  logic [NumW-1:0] num_d, num_q;
  logic [ProdW:0] div_rem_d, div_rem_q;
  logic [CntW-1:0] div_cnt_d, div_cnt_q;
  status_t stat_d, stat_q;

  logic out_valid_d;
  dur_t out_dur_d;
  status_t out_stat_d;

  logic in_acc;
  logic [31:0] shift_next;
  logic [1:0] idx_next;
  logic [31:0] padded;
  logic [ProdW:0] rem_shift;
  logic slot_free;

  assign in_stall_o = (ctl_q != C_PARSE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign shift_next = {file_byte_i, field_q[31:8]};
  assign idx_next   = idx_q + 2'd1;
  assign padded     = shift_next[31] ? 32'd0 : (shift_next + {31'd0, shift_next[0]});
  assign rem_shift  = {div_rem_q[ProdW-1:0], num_q[NumW-1]};
  assign slot_free  = !out_valid_o || !out_stall_i;

  always_comb begin
    ctl_phase_d = phase_q;
    byte_cnt_d  = byte_cnt_q;
    field_d     = field_q;
    idx_d       = idx_q;
    tag_d       = tag_q;
    rem_cnt_d   = rem_cnt_q;
    fmt_taken_d = fmt_taken_q;
    rate_d      = rate_q;
    align_d     = align_q;
    data_len_d  = data_len_q;
    err_d       = err_q;
    ctl_d       = ctl_q;
    prod_d      = prod_q;
    num_d       = num_q;
    div_rem_d   = div_rem_q;
    div_cnt_d   = div_cnt_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_o;
    out_dur_d   = duration_ms_o;
    out_stat_d  = status_o;

    if (out_valid_o && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_acc) begin
      if (byte_cnt_q < MinFileBytes) begin
        byte_cnt_d = byte_cnt_q + 6'd1;
      end
      unique case (phase_q)
        P_RIFF, P_RLEN, P_WAVE, P_CID, P_CSIZE: begin
          field_d = shift_next;
          idx_d   = idx_next;
          if (idx_next == 2'd0) begin
            unique case (phase_q)
              P_RIFF: begin
                if (shift_next != TagRiff) begin
                  err_d = StatusNotWave;
                  ctl_phase_d = P_HALT;
                end else begin
                  ctl_phase_d = P_RLEN;
                end
              end
              P_RLEN: ctl_phase_d = P_WAVE;
              P_WAVE: begin
                if (shift_next != TagWave) begin
                  err_d = StatusNotWave;
                  ctl_phase_d = P_HALT;
                end else begin
                  ctl_phase_d = P_CID;
                end
              end
              P_CID: begin
                tag_d = shift_next;
                ctl_phase_d = P_CSIZE;
              end
              default: begin
                if (tag_q == TagFmt) begin
                  rem_cnt_d   = padded;
                  fmt_taken_d = 5'd0;
                  if (padded < {27'd0, FmtNeeded}) begin
                    err_d = StatusShortFmt;
                    ctl_phase_d = P_HALT;
                  end else begin
                    ctl_phase_d = P_FMT;
                  end
                end else if (tag_q == TagData) begin
                  data_len_d = shift_next;
                  if (shift_next == 32'd0 || shift_next[31]) begin
                    err_d = StatusBadData;
                    ctl_phase_d = P_HALT;
                  end else begin
                    ctl_phase_d = P_DATA;
                  end
                end else begin
                  rem_cnt_d = padded;
                  ctl_phase_d = (padded != 32'd0) ? P_SKIP : P_CID;
                end
              end
            endcase
          end
        end
        P_FMT: begin
          if (fmt_taken_q < FmtNeeded) begin
            case (fmt_taken_q)
              5'd4:    rate_d[7:0]   = file_byte_i;
              5'd5:    rate_d[15:8]  = file_byte_i;
              5'd6:    rate_d[23:16] = file_byte_i;
              5'd7:    rate_d[31:24] = file_byte_i;
              5'd12:   align_d[7:0]  = file_byte_i;
              5'd13:   align_d[15:8] = file_byte_i;
              default: ;
            endcase
            fmt_taken_d = fmt_taken_q + 5'd1;
          end
          rem_cnt_d = rem_cnt_q - 32'd1;
          if (rem_cnt_q == 32'd1) begin
            ctl_phase_d = P_CID;
          end
        end
        P_SKIP: begin
          rem_cnt_d = rem_cnt_q - 32'd1;
          if (rem_cnt_q == 32'd1) begin
            ctl_phase_d = P_CID;
          end
        end
        default: ;
      endcase
      if (last_byte_i) begin
        ctl_d = C_MULT;
      end
    end

    unique case (ctl_q)
      C_PARSE: ;
      C_MULT: begin
        prod_d = ProdW'(rate_q) * ProdW'(align_q);
        num_d  = NumW'(data_len_q) * NumW'(Thousand);
        ctl_d  = C_CHECK;
      end
      C_CHECK: begin
        div_rem_d = '0;
        div_cnt_d = '0;
        ctl_d     = C_HOLD;
        if (byte_cnt_q < MinFileBytes) begin
          stat_d = StatusNotWave;
        end else if (err_q != StatusOk) begin
          stat_d = err_q;
        end else if (phase_q == P_DATA && prod_q > ProdW'(Thousand)) begin
          stat_d = StatusOk;
          ctl_d  = C_DIV;
        end else if (phase_q == P_FMT && fmt_taken_q < FmtNeeded) begin
          stat_d = StatusShortFmt;
        end else begin
          stat_d = StatusBadData;
        end
        if (ctl_d == C_HOLD) begin
          num_d = '0;
        end
        ctl_phase_d = P_RIFF;
        byte_cnt_d  = '0;
        field_d     = '0;
        idx_d       = '0;
        tag_d       = '0;
        rem_cnt_d   = '0;
        fmt_taken_d = '0;
        rate_d      = '0;
        align_d     = '0;
        data_len_d  = '0;
        err_d       = StatusOk;
      end
      C_DIV: begin
        if (rem_shift >= {1'b0, prod_q}) begin
          div_rem_d = rem_shift - {1'b0, prod_q};
          num_d     = {num_q[NumW-2:0], 1'b1};
        end else begin
          div_rem_d = rem_shift;
          num_d     = {num_q[NumW-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + CntW'(1);
        if (div_cnt_q == CntW'(NumW - 1)) begin
          ctl_d = C_HOLD;
        end
      end
      C_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_dur_d   = num_q[DurW-1:0];
          out_stat_d  = stat_q;
          ctl_d       = C_PARSE;
        end
      end
      default: ctl_d = C_PARSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q         <= C_PARSE;
      phase_q       <= P_RIFF;
      byte_cnt_q    <= '0;
      field_q       <= '0;
      idx_q         <= '0;
      tag_q         <= '0;
      rem_cnt_q     <= '0;
      fmt_taken_q   <= '0;
      rate_q        <= '0;
      align_q       <= '0;
      data_len_q    <= '0;
      err_q         <= StatusOk;
      prod_q        <= '0;
      num_q         <= '0;
      div_rem_q     <= '0;
      div_cnt_q     <= '0;
      stat_q        <= StatusOk;
      out_valid_o   <= 1'b0;
      duration_ms_o <= '0;
      status_o      <= StatusOk;
    end else begin
      ctl_q         <= ctl_d;
      phase_q       <= ctl_phase_d;
      byte_cnt_q    <= byte_cnt_d;
      field_q       <= field_d;
      idx_q         <= idx_d;
      tag_q         <= tag_d;
      rem_cnt_q     <= rem_cnt_d;
      fmt_taken_q   <= fmt_taken_d;
      rate_q        <= rate_d;
      align_q       <= align_d;
      data_len_q    <= data_len_d;
      err_q         <= err_d;
      prod_q        <= prod_d;
      num_q         <= num_d;
      div_rem_q     <= div_rem_d;
      div_cnt_q     <= div_cnt_d;
      stat_q        <= stat_d;
      out_valid_o   <= out_valid_d;
      duration_ms_o <= out_dur_d;
      status_o      <= out_stat_d;
    end
  end

  `WHDP_ASSERT_IMP(a_err_zero_dur, out_valid_o && (status_o != StatusOk),
                   duration_ms_o == '0, "error result with nonzero duration")
  `WHDP_ASSERT_NEXT(a_last_starts, in_acc && last_byte_i, ctl_q == C_MULT,
                    "final byte did not start the result")
  `WHDP_ASSERT_IMP(a_byte_cnt_sat, 1'b1, byte_cnt_q <= MinFileBytes,
                   "byte count beyond saturation")
  `WHDP_ASSERT_IMP(a_fmt_taken_max, 1'b1, fmt_taken_q <= FmtNeeded,
                   "fmt byte count beyond limit")

endmodule

`default_nettype wire

// ===== sim/wave_header_duration_parser_test.sv =====
// Self-checking testbench for the wave header parser: streams whole wave files byte by byte
// and checks each duration and status against a built-in header walker.
// Depends on whdp_pkg and on the wave_header_duration_parser top level.
`timescale 1ns / 1ps

module wave_header_duration_parser_test;
  import whdp_pkg::*;

  localparam int QuietLimit = 2000;

  typedef enum logic [3:0] {
    PhRiff, PhRiffLen, PhWave, PhChunkId, PhChunkSize, PhFmt, PhSkip, PhData, PhHalt
  } walk_phase_e;

  typedef struct packed {
    dur_t    dur;
    status_t status;
  } wav_result_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  byte_t   file_byte_i = '0;
  logic    last_byte_i = 1'b0;
  logic    out_stall_i = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  dur_t    duration_ms_o;
  status_t status_o;

  wave_header_duration_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .file_byte_i   (file_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duration_ms_o (duration_ms_o),
    .status_o      (status_o)
  );

  always #2 clk_i = ~clk_i;

  // Header walker state.
  walk_phase_e walk_phase   = PhRiff;
  int          seen_bytes   = 0;
  logic [31:0] dword_acc    = '0;
  logic [1:0]  dword_idx    = '0;
  logic [31:0] cur_tag      = '0;
  logic [31:0] body_left    = '0;
  logic [4:0]  fmt_taken    = '0;
  logic [31:0] fmt_rate     = '0;
  logic [15:0] fmt_align    = '0;
  logic [31:0] data_size    = '0;
  status_t     halt_code    = StatusOk;

  wav_result_t expected_durations[$];
  byte_t       wav_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_left     = 0;
  int          tx_gap_max     = 0;
  int          rx_stall_max   = 0;

  function automatic void clear_walk();
    walk_phase = PhRiff;
    seen_bytes = 0;
    dword_acc  = '0;
    dword_idx  = '0;
    cur_tag    = '0;
    body_left  = '0;
    fmt_taken  = '0;
    fmt_rate   = '0;
    fmt_align  = '0;
    data_size  = '0;
    halt_code  = StatusOk;
  endfunction

  function automatic logic [31:0] padded_body(input logic [31:0] size);
    if (size[31]) return '0;
    return (size + 32'd1) & ~32'd1;
  endfunction

  function automatic void halt_walk(input status_t code);
    halt_code  = code;
    walk_phase = PhHalt;
  endfunction

  function automatic void close_header(input logic [31:0] size);
    if (cur_tag == TagFmt) begin
      body_left = padded_body(size);
      fmt_taken = '0;
      if (body_left < 32'(FmtNeeded)) halt_walk(StatusShortFmt);
      else walk_phase = PhFmt;
    end else if (cur_tag == TagData) begin
      data_size = size;
      if (size == '0 || size[31]) halt_walk(StatusBadData);
      else walk_phase = PhData;
    end else begin
      body_left = padded_body(size);
      if (body_left != '0) walk_phase = PhSkip;
      else walk_phase = PhChunkId;
    end
  endfunction

  // Advances the walker by one byte; returns 1 when the byte ends a file.
  function automatic bit walk_wave_byte(input byte_t b, input logic last,
                                        output dur_t dur, output status_t st);
    logic [63:0] product;
    int k;
    dur = '0;
    st  = StatusOk;
    if (seen_bytes < int'(MinFileBytes)) seen_bytes++;
    case (walk_phase)
      PhRiff, PhRiffLen, PhWave, PhChunkId, PhChunkSize: begin
        dword_acc = {b, dword_acc[31:8]};
        dword_idx = dword_idx + 2'd1;
        if (dword_idx == 2'd0) begin
          case (walk_phase)
            PhRiff: begin
              if (dword_acc != TagRiff) halt_walk(StatusNotWave);
              else walk_phase = PhRiffLen;
            end
            PhRiffLen: walk_phase = PhWave;
            PhWave: begin
              if (dword_acc != TagWave) halt_walk(StatusNotWave);
              else walk_phase = PhChunkId;
            end
            PhChunkId: begin
              cur_tag    = dword_acc;
              walk_phase = PhChunkSize;
            end
            default: close_header(dword_acc);
          endcase
        end
      end
      PhFmt: begin
        k = int'(fmt_taken);
        if (fmt_taken < FmtNeeded) begin
          if (k >= 4 && k < 8) fmt_rate[(k - 4) * 8 +: 8] = b;
          else if (k == 12) fmt_align[7:0] = b;
          else if (k == 13) fmt_align[15:8] = b;
          fmt_taken = fmt_taken + 5'd1;
        end
        body_left = body_left - 32'd1;
        if (body_left == '0) walk_phase = PhChunkId;
      end
      PhSkip: begin
        body_left = body_left - 32'd1;
        if (body_left == '0) walk_phase = PhChunkId;
      end
      default: ;
    endcase
    if (!last) return 1'b0;
    product = 64'(fmt_rate) * 64'(fmt_align);
    if (seen_bytes < int'(MinFileBytes)) begin
      st = StatusNotWave;
    end else if (halt_code != StatusOk) begin
      st = halt_code;
    end else if (walk_phase == PhData && product > 64'(Thousand)) begin
      dur = dur_t'((64'(data_size) * 64'(Thousand)) / product);
    end else if (walk_phase == PhFmt && fmt_taken < FmtNeeded) begin
      st = StatusShortFmt;
    end else begin
      st = StatusBadData;
    end
    clear_walk();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Result side: random stall after each transfer, and the comparison.
  always @(posedge clk_i) begin
    int unsigned n;
    wav_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_durations.size() == 0) begin
          report_mismatch("result with nothing pending, duration", duration_ms_o, 0);
        end else begin
          want = expected_durations.pop_front();
          if (duration_ms_o !== want.dur)
            report_mismatch("duration_ms", duration_ms_o, want.dur);
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        n = $urandom_range(0, rx_stall_max);
        stall_left  <= n;
        out_stall_i <= (n != 0);
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no transfer for %0d cycles", QuietLimit);
        $display("** wave_header_duration_parser: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    dur_t dur;
    status_t st;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    file_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (walk_wave_byte(b, last, dur, st)) expected_durations.push_back('{dur, st});
  endtask

  task automatic send_wav();
    foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
    wav_bytes.delete();
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_durations.size() != 0);
  endtask

  task automatic add_dword(input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic add_random_bytes(input int n);
    repeat (n) wav_bytes.push_back(byte_t'($urandom));
  endtask

  task automatic add_riff_wave(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
    add_dword(riff_tag);
    add_dword($urandom);
    add_dword(wave_tag);
  endtask

  task automatic add_fmt(input logic [31:0] size, input logic [31:0] rate_v,
                         input logic [15:0] align_v, input int body_len);
    byte_t v;
    add_dword(TagFmt);
    add_dword(size);
    for (int i = 0; i < body_len; i++) begin
      v = byte_t'($urandom);
      if (i >= 4 && i < 8) v = rate_v[8 * (i - 4) +: 8];
      else if (i == 12) v = align_v[7:0];
      else if (i == 13) v = align_v[15:8];
      wav_bytes.push_back(v);
    end
  endtask

  task automatic add_chunk(input logic [31:0] tag, input logic [31:0] size, input int body_len);
    add_dword(tag);
    add_dword(size);
    add_random_bytes(body_len);
  endtask

  task automatic add_data(input logic [31:0] size, input int tail);
    add_dword(TagData);
    add_dword(size);
    add_random_bytes(tail);
  endtask

  task automatic trim_wav(input int keep);
    while (wav_bytes.size() > keep) wav_bytes.delete(wav_bytes.size() - 1);
  endtask

  task automatic add_random_chunk();
    logic [31:0] size;
    if ($urandom_range(0, 4) == 0) size = 32'h8000_0000 | $urandom;
    else size = $urandom_range(0, 7);
    add_chunk($urandom, size, int'(padded_body(size)));
  endtask

  function automatic logic [31:0] random_data_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 32'h8000_0000 | $urandom;
      2, 3, 4, 5, 6, 7, 8, 9: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(1, 1000000);
    endcase
  endfunction

  task automatic test_good_files();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'd176400, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'hFFFF_FFFF, 16'hFFFF, 16);
    add_data(32'h7FFF_FFFF, 3);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd1, 16'd1001, 16);
    add_data(32'h7FFF_FFFF, 0);
    send_wav();
    tx_gap_max   = 10;
    rx_stall_max = 10;
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd1001, 16'd1, 16);
    add_data(32'd1, 1);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd15, 32'd8000, 16'd2, 16);
    add_data(32'd32000, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd19, 32'd96000, 16'd6, 20);
    add_data(32'd1234567, 5);
    send_wav();
    wait_results_drained();
  endtask

  task automatic test_tag_errors();
    add_riff_wave(TagRiff ^ 32'h0000_0100, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'd1000, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave ^ 32'h8000_0000);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'd1000, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'd1000, 0);
    trim_wav(int'(MinFileBytes) - 1);
    send_wav();
    add_random_bytes(1);
    send_wav();
    wait_results_drained();
  endtask

  task automatic test_fmt_errors();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd14, 32'd44100, 16'd4, 14);
    add_data(32'd1000, 4);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'h8000_0010, 32'd44100, 16'd4, 16);
    add_data(32'd1000, 0);
    send_wav();
    // The file ends inside the fmt body but is long enough overall.
    add_riff_wave(TagRiff, TagWave);
    add_chunk(32'h5453_494C, 32'd20, 20);
    add_fmt(32'd16, 32'd44100, 16'd4, 10);
    send_wav();
    // A later fmt chunk replaces the earlier one.
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd1, 16'd1, 16);
    add_fmt(32'd16, 32'd48000, 16'd4, 16);
    add_data(32'd960000, 2);
    send_wav();
    wait_results_drained();
  endtask

  task automatic test_data_errors();
    add_riff_wave(TagRiff, TagWave);
    add_data(32'd1000, 0);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'd0, 2);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'h8000_0000, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd1000, 16'd1, 16);
    add_data(32'd5000, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd0, 16'hFFFF, 16);
    add_data(32'd5000, 0);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_chunk(32'h7473_696C, 32'd3, 4);
    send_wav();
    add_riff_wave(TagRiff, TagWave);
    add_fmt(32'd16, 32'd44100, 16'd4, 16);
    add_data(32'd176400, 0);
    trim_wav(wav_bytes.size() - 2);
    send_wav();
    wait_results_drained();
  endtask

  task automatic test_chunk_walk();
    add_riff_wave(TagRiff, TagWave);
    add_chunk(32'h6B6E_756A, 32'd3, 4);
    add_chunk(32'h7473_696C, 32'd0, 0);
    add_chunk(32'h6F66_6E69, 32'h8000_0005, 0);
    add_fmt(32'd16, 32'd22050, 16'd2, 16);
    add_chunk(32'h7473_6166, 32'd1, 2);
    add_data(32'd441000, 3);
    send_wav();
    wait_results_drained();
  endtask

  task automatic build_random_wav();
    logic [31:0] size;
    logic [31:0] rate_v;
    logic [15:0] align_v;
    bit data_first;
    if ($urandom_range(0, 19) == 0) begin
      add_random_bytes($urandom_range(1, 60));
      return;
    end
    add_riff_wave(($urandom_range(0, 29) == 0) ? $urandom : TagRiff,
                  ($urandom_range(0, 29) == 0) ? $urandom : TagWave);
    data_first = ($urandom_range(0, 19) == 0);
    if (data_first) add_data(random_data_size(), 0);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) add_random_chunk();
    case ($urandom_range(0, 19))
      0, 1:    size = $urandom_range(0, 15);
      2:       size = 32'h8000_0000 | $urandom;
      default: size = $urandom_range(16, 21);
    endcase
    case ($urandom_range(0, 3))
      0: begin
        rate_v  = $urandom_range(8000, 192000);
        align_v = $urandom_range(1, 8);
      end
      1: begin
        rate_v  = $urandom;
        align_v = $urandom;
      end
      2: begin
        rate_v  = $urandom_range(1, 2000);
        align_v = $urandom_range(0, 3);
      end
      default: begin
        rate_v  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        align_v = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
      end
    endcase
    add_fmt(size, rate_v, align_v,
            size[31] ? $urandom_range(0, 20) : int'(padded_body(size)));
    if ($urandom_range(0, 3) == 0) add_random_chunk();
    if (!data_first) add_data(random_data_size(), $urandom_range(0, 6));
    if ($urandom_range(0, 11) == 0) trim_wav($urandom_range(1, wav_bytes.size()));
  endtask

  task automatic test_random_files();
    int files;
    files = 0;
    while (bytes_sent < 1750) begin
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      build_random_wav();
      send_wav();
      files++;
      if (files % 8 == 0) wait_results_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_good_files();
    test_tag_errors();
    test_fmt_errors();
    test_data_errors();
    test_chunk_walk();
    test_random_files();
    wait_results_drained();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** wave_header_duration_parser: PASSED **");
    end else begin
      $display("** wave_header_duration_parser: FAILED **");
    end
    $finish;
  end

endmodule
